### rtl/core/box_downsample_2x2_rgb32_assert.svh
// Shared assertion macros; clk and arst_n are taken from the including module.
`ifndef BOX_DOWNSAMPLE_2X2_RGB32_ASSERT_SVH
`define BOX_DOWNSAMPLE_2X2_RGB32_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define BDSAMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define BDSAMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bdsamp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdsamp_pkg;

	localparam int PIXEL_BITS = 32;
	localparam int LANE_BITS = 8;
	localparam int LANES = PIXEL_BITS / LANE_BITS;
	localparam int ROW_WIDTH_BITS = 13;
	localparam int MIN_ROW_WIDTH = 2;
	localparam int RESET_ROW_WIDTH = 4096;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [ROW_WIDTH_BITS-1:0] row_width_t;

	// Per-word position flags handed from the column tracker to the filter stage.
	typedef struct packed {
		logic odd_row;
		logic col_odd;
		logic in_range;
		logic row_end;
	} bdsamp_ctl_t;

	// Lane-wise rounded mean (a+b+1)>>1.
	function automatic pixel_t lane_avg(input pixel_t a, input pixel_t b);
		logic [LANE_BITS:0] s;
		pixel_t r;
		r = '0;
		for (int i = 0; i < LANES; i++) begin
			s = {1'b0, a[LANE_BITS*i +: LANE_BITS]} + {1'b0, b[LANE_BITS*i +: LANE_BITS]}
				+ (LANE_BITS+1)'(1);
			r[LANE_BITS*i +: LANE_BITS] = s[LANE_BITS:1];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/bdsamp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdsamp_in_if;
	import bdsamp_pkg::*;

	logic valid;
	logic ready;
	pixel_t pixel_in;

	modport source(output valid, output pixel_in, input ready);
	modport sink(input valid, input pixel_in, output ready);
endinterface

interface bdsamp_out_if;
	import bdsamp_pkg::*;

	logic valid;
	logic ready;
	pixel_t pixel_out;
	logic row_end;

	modport source(output valid, output pixel_out, output row_end, input ready);
	modport sink(input valid, input pixel_out, input row_end, output ready);
endinterface

`default_nettype wire

### rtl/core/box_downsample_2x2_rgb32.sv
`timescale 1ns / 1ps
`default_nettype none

// 2x2 box downsampler for a raster stream of 32-bit pixels (four 8-bit lanes).
// Takes one pixel word per clock unless the output stalls; the pixel that completes
// a block passes the line store read stage, then the output register.
// The rate is set by the single-port line store of MAX_WIDTH x 32 bits, which is
// written on even rows and read once per pixel on every row. Each output lane is
// the rounded mean of two rounded column means, row_end marks the last block of
// a row, and an odd trailing column is dropped. pixels.ready follows blocks.ready
// only when the filter stage holds a finished block and the output word waits.
// Program row_width (clamped to 2..MAX_WIDTH) only while no pixel is in flight.
module box_downsample_2x2_rgb32 #(
	parameter int MAX_WIDTH = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire bdsamp_pkg::row_width_t cfg_wdata,
	bdsamp_in_if.sink pixels,
	bdsamp_out_if.source blocks
);
	import bdsamp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic accept;
	logic s1_free;
	logic store_en;
	logic [CW-1:0] col;
	bdsamp_ctl_t ctl;
	pixel_t top_s1;

	assign pixels.ready = s1_free;
	assign accept = pixels.valid && s1_free;

	bdsamp_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.col(col),
		.store_en(store_en),
		.ctl(ctl)
	);

	bdsamp_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk(clk),
		.wr_en(store_en),
		.rd_en(accept),
		.addr(col),
		.wdata(pixels.pixel_in),
		.top_s1(top_s1)
	);

	bdsamp_reduce u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.pixel(pixels.pixel_in),
		.ctl(ctl),
		.top_s1(top_s1),
		.s1_free(s1_free),
		.blocks(blocks)
	);

endmodule

`default_nettype wire

### rtl/core/bdsamp_line_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bdsamp_line_store #(
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic rd_en,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire bdsamp_pkg::pixel_t wdata,
	output bdsamp_pkg::pixel_t top_s1
);
	import bdsamp_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			top_s1 <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/bdsamp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "box_downsample_2x2_rgb32_assert.svh"

module bdsamp_ctrl #(
	parameter int MAX_WIDTH = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire bdsamp_pkg::row_width_t cfg_wdata,
	input wire logic accept,
	output logic [$clog2(MAX_WIDTH)-1:0] col,
	output logic store_en,
	output bdsamp_pkg::bdsamp_ctl_t ctl
);
	import bdsamp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CLW = (ROW_WIDTH_BITS > CW + 1) ? ROW_WIDTH_BITS : CW + 1;
	localparam int RST_W = (RESET_ROW_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_ROW_WIDTH;
	localparam int RST_LAST = RST_W - 1;
	localparam int RST_PAIR = RST_W / 2 - 1;

	logic [CW-1:0] col_q;
	logic odd_q;
	logic [CW-1:0] last_col_q;
	logic [CW-2:0] pair_last_q;
	logic [CLW-1:0] rw_ext;
	logic [CLW-1:0] width_clamped;
	logic [CLW-1:0] pair_count;
	logic wrap;

	// Clamp the programmed width to [2, MAX_WIDTH].
	always_comb begin
		rw_ext = CLW'(cfg_wdata);
		if (rw_ext < CLW'(MIN_ROW_WIDTH)) begin
			width_clamped = CLW'(MIN_ROW_WIDTH);
		end else if (rw_ext > CLW'(MAX_WIDTH)) begin
			width_clamped = CLW'(MAX_WIDTH);
		end else begin
			width_clamped = rw_ext;
		end
		pair_count = width_clamped >> 1;
	end

	assign wrap = col_q >= last_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
			last_col_q <= CW'(RST_LAST);
			pair_last_q <= (CW-1)'(RST_PAIR);
		end else begin
			if (cfg_we) begin
				last_col_q <= CW'(width_clamped - CLW'(1));
				pair_last_q <= (CW-1)'(pair_count - CLW'(1));
			end
			if (accept) begin
				if (wrap) begin
					col_q <= '0;
					odd_q <= ~odd_q;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	assign col = col_q;
	assign store_en = accept && !odd_q;

	always_comb begin
		ctl.odd_row = odd_q;
		ctl.col_odd = col_q[0];
		ctl.in_range = col_q[CW-1:1] <= pair_last_q;
		ctl.row_end = col_q[CW-1:1] == pair_last_q;
	end

	`BDSAMP_ASSERT_NEXT(a_row_wrap, accept && wrap, col_q == '0 && odd_q != $past(odd_q), "row wrap missed")
	`BDSAMP_ASSERT_NEXT(a_col_step, accept && !wrap && !cfg_we, col_q == $past(col_q) + 1'b1, "column did not advance")

endmodule

`default_nettype wire

### rtl/core/bdsamp_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

`include "box_downsample_2x2_rgb32_assert.svh"

module bdsamp_reduce (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire bdsamp_pkg::pixel_t pixel,
	input wire bdsamp_pkg::bdsamp_ctl_t ctl,
	input wire bdsamp_pkg::pixel_t top_s1,
	output logic s1_free,
	bdsamp_out_if.source blocks
);
	import bdsamp_pkg::*;

	logic valid_s1;
	pixel_t pixel_s1;
	bdsamp_ctl_t ctl_s1;
	pixel_t held_q;
	logic out_valid_q;
	pixel_t pixel_out_q;
	logic row_end_q;

	pixel_t vert;
	logic has_out;
	logic hold_vert;
	logic s1_fire;

	assign vert = lane_avg(top_s1, pixel_s1);
	assign has_out = ctl_s1.odd_row && ctl_s1.in_range && ctl_s1.col_odd;
	assign hold_vert = ctl_s1.odd_row && ctl_s1.in_range && !ctl_s1.col_odd;

	// Stage only waits when it has a block to hand over and the output word is stuck.
	assign s1_fire = valid_s1 && (!has_out || !out_valid_q || blocks.ready);
	assign s1_free = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			held_q <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s1_fire && hold_vert) begin
				held_q <= vert;
			end
			if (s1_fire && has_out) begin
				out_valid_q <= 1'b1;
			end else if (blocks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			ctl_s1 <= ctl;
		end
		if (s1_fire && has_out) begin
			pixel_out_q <= lane_avg(held_q, vert);
			row_end_q <= ctl_s1.row_end;
		end
	end

	assign blocks.valid = out_valid_q;
	assign blocks.pixel_out = pixel_out_q;
	assign blocks.row_end = row_end_q;

	`BDSAMP_ASSERT_NEXT(a_block_lands, s1_fire && has_out, out_valid_q, "block lost")
	`BDSAMP_ASSERT_NOW(a_stall_holds, valid_s1 && has_out && out_valid_q && !blocks.ready, !s1_free, "stage overrun")

endmodule

`default_nettype wire
